[hdl/sffd_pkg.sv]
// Shared constants, record codes, queue entry type and digit helper for the
// sensor frame field decoder. No dependencies.
package sffd_pkg;

   localparam int MAX_FRAME_LEN = 40;
   localparam int STORED_BYTES  = 16;
   localparam int POS_W         = 6;
   localparam int IDX_W         = $clog2(STORED_BYTES);
   localparam int NUM_DIGITS    = 9;   // frame positions 6..14
   localparam int FIRST_DIGIT   = 6;

   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam int VALUE_W       = 33;
   localparam int CO2_W         = 16;

   localparam logic [CO2_W-1:0] CO2_LIMIT_RESET = 16'd3000;
   localparam logic [CO2_W-1:0] CO2_LAST_RESET  = 16'd800;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_ONE    = 8'h31;
   localparam logic [7:0] CHAR_TWO    = 8'h32;
   localparam logic [7:0] CHAR_UC_C   = 8'h43;
   localparam logic [7:0] CHAR_G      = 8'h67;
   localparam logic [7:0] CHAR_H      = 8'h68;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;

   localparam logic [3:0] KIND_TEMP1    = 4'd0;
   localparam logic [3:0] KIND_PRES1    = 4'd1;
   localparam logic [3:0] KIND_HUMI1    = 4'd2;
   localparam logic [3:0] KIND_GASRES   = 4'd3;
   localparam logic [3:0] KIND_HUMI2    = 4'd4;
   localparam logic [3:0] KIND_TEMP2    = 4'd5;
   localparam logic [3:0] KIND_CO2      = 4'd6;
   localparam logic [3:0] KIND_GAS1     = 4'd7;
   localparam logic [3:0] KIND_CO2_REJ  = 4'd8;

   typedef struct packed {
      logic [3:0]                  kind;
      logic [NUM_DIGITS-1:0][7:0]  raw;   // raw[0] is frame position 6
   } sffd_rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } sffd_qstat_type;

   // byte minus '0', zero extended and taken as a signed 16-bit value
   function automatic logic signed [15:0] digit16(input logic [7:0] b);
      logic signed [15:0] d;
      d = $signed({8'd0, b}) - $signed({8'd0, CHAR_ZERO});
      return d;
   endfunction

endpackage

[hdl/sffd_front.sv]
// Front end: takes bytes, tracks the open frame and its stored bytes, and
// classifies a closing '*' into a record for the queue. Uses sffd_pkg.
module sffd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_rx_byte,
   input  sffd_pkg::sffd_qstat_type q_stat,
   output logic                  push,
   output sffd_pkg::sffd_rec_type push_rec
);
   import sffd_pkg::*;

   logic                 in_frame_ff, in_frame_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [7:0]           bytes_ff [STORED_BYTES];
   logic [7:0]           view [STORED_BYTES];
   logic                 accept, open, is_star, wr_pos, store, match;
   logic [3:0]           kind;

   assign req_ready = !q_stat.full;

   always_comb begin
      accept  = req_valid && req_ready;
      is_star = (req_rx_byte == CHAR_STAR);
      open    = in_frame_ff || (req_rx_byte == CHAR_DOLLAR);
      wr_pos  = open && (pos_ff < POS_W'(MAX_FRAME_LEN));
      store   = wr_pos && (pos_ff < POS_W'(STORED_BYTES));

      for (int i = 0; i < STORED_BYTES; i++) begin
         view[i] = (store && pos_ff[IDX_W-1:0] == IDX_W'(i)) ? req_rx_byte : bytes_ff[i];
      end

      match = 1'b1;
      kind  = KIND_TEMP1;
      priority if (view[1] == CHAR_T && view[5] == CHAR_ONE) begin
         kind = KIND_TEMP1;
      end else if (view[2] == CHAR_R && view[5] == CHAR_ONE) begin
         kind = KIND_PRES1;
      end else if (view[1] == CHAR_H && view[5] == CHAR_ONE) begin
         kind = KIND_HUMI1;
      end else if (view[1] == CHAR_G) begin
         kind = KIND_GASRES;
      end else if (view[1] == CHAR_H && view[5] == CHAR_TWO) begin
         kind = KIND_HUMI2;
      end else if (view[1] == CHAR_T && view[5] == CHAR_TWO) begin
         kind = KIND_TEMP2;
      end else if (view[1] == CHAR_UC_C) begin
         kind = KIND_CO2;
      end else if (view[2] == CHAR_G && view[5] == CHAR_ONE) begin
         kind = KIND_GAS1;
      end else begin
         match = 1'b0;
      end

      push_rec.kind = kind;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         push_rec.raw[i] = view[FIRST_DIGIT + i];
      end
      push = accept && open && is_star && match;

      in_frame_in = open && !is_star;
      if (!open || is_star) begin
         pos_in = '0;
      end else if (wr_pos) begin
         pos_in = pos_ff + POS_W'(1);
      end else begin
         pos_in = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         pos_ff      <= '0;
         for (int i = 0; i < STORED_BYTES; i++) begin
            bytes_ff[i] <= '0;
         end
      end else if (accept) begin
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
         if (store) begin
            bytes_ff[pos_ff[IDX_W-1:0]] <= req_rx_byte;
         end
      end
   end

endmodule

[hdl/sffd_queue.sv]
// Short record queue between front and back end.
// Uses sffd_pkg for depth and entry type.
module sffd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  sffd_pkg::sffd_rec_type  push_rec,
   input  logic                    pop,
   output sffd_pkg::sffd_rec_type  head_rec,
   output sffd_pkg::sffd_qstat_type stat
);
   import sffd_pkg::*;

   sffd_rec_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wptr_ff, rptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                do_push, do_pop;

   always_comb begin
      stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
      stat.empty = (count_ff == '0);
      do_push    = push && !stat.full;
      do_pop     = pop && !stat.empty;
      head_rec   = entry_ff[rptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wptr_ff <= wptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rptr_ff <= rptr_ff + QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

endmodule

[hdl/sffd_back.sv]
// Back end: digit arithmetic in stages 1 and 2, CO2 jump check and output register.
// Uses sffd_pkg.
module sffd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  sffd_pkg::sffd_qstat_type      q_stat,
   input  sffd_pkg::sffd_rec_type        head_rec,
   output logic                          pop,
   input  logic [sffd_pkg::CO2_W-1:0]    co2_jump_limit,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [3:0]                    rsp_record_kind,
   output logic signed [sffd_pkg::VALUE_W-1:0] rsp_value_hundredths
);
   import sffd_pkg::*;

   // stage 1: three-digit groups and two-digit t and lo groups
   logic                s1_valid_ff;
   logic [3:0]          s1_kind_ff;
   logic signed [15:0]  s1_hi_ff, s1_mid_ff, s1_t_ff, s1_lo_ff;
   // stage 2: six-digit sum, hi group times 100, t and lo groups
   logic                s2_valid_ff;
   logic [3:0]          s2_kind_ff;
   logic signed [25:0]  s2_six_ff;
   logic signed [VALUE_W-1:0] s2_hi100_ff;
   logic signed [15:0]  s2_t_ff, s2_lo_ff;
   // output
   logic                out_valid_ff;
   logic [3:0]          out_kind_ff, out_kind_in;
   logic signed [VALUE_W-1:0] out_value_ff, out_value_in;
   logic [CO2_W-1:0]    last_co2_ff;

   logic                out_free, s2_free, s1_free;
   logic signed [15:0]  e [NUM_DIGITS];
   logic signed [15:0]  hi_in, mid_in, t_in, lo_in;
   logic signed [25:0]  six_in;
   logic signed [VALUE_W-1:0] six100, cand100;
   logic [CO2_W-1:0]    cand;
   logic signed [17:0]  diff, lim;
   logic                co2_ok;

   assign out_free = !out_valid_ff || rsp_ready;
   assign s2_free  = !s2_valid_ff || out_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign pop      = !q_stat.empty && s1_free;

   assign rsp_valid            = out_valid_ff;
   assign rsp_record_kind      = out_kind_ff;
   assign rsp_value_hundredths = out_value_ff;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         e[i] = digit16(head_rec.raw[i]);
      end
      hi_in  = e[0] * 16'sd100 + e[1] * 16'sd10 + e[2];
      mid_in = e[3] * 16'sd100 + e[4] * 16'sd10 + e[5];
      t_in   = e[4] * 16'sd10 + e[5];
      lo_in  = e[7] * 16'sd10 + e[8];

      six_in = 26'(s1_hi_ff) * 26'sd1000 + 26'(s1_mid_ff);

      six100  = 33'(s2_six_ff) * 33'sd100;
      cand    = s2_six_ff[CO2_W-1:0];
      cand100 = $signed({17'd0, cand}) * 33'sd100;
      diff    = $signed({2'b00, cand}) - $signed({2'b00, last_co2_ff});
      lim     = $signed({2'b00, co2_jump_limit});
      co2_ok  = (diff < lim) && (diff > -lim);

      out_kind_in = s2_kind_ff;
      unique case (s2_kind_ff)
         KIND_TEMP1, KIND_HUMI1: out_value_in = s2_hi100_ff + 33'(s2_t_ff);
         KIND_PRES1, KIND_GASRES: out_value_in = six100 + 33'(s2_lo_ff);
         KIND_HUMI2, KIND_TEMP2: out_value_in = s2_hi100_ff;
         KIND_GAS1: out_value_in = six100;
         default: begin
            out_value_in = cand100;
            out_kind_in  = co2_ok ? KIND_CO2 : KIND_CO2_REJ;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_kind_ff <= head_rec.kind;
         s1_hi_ff   <= hi_in;
         s1_mid_ff  <= mid_in;
         s1_t_ff    <= t_in;
         s1_lo_ff   <= lo_in;
      end
      if (s2_free) begin
         s2_kind_ff  <= s1_kind_ff;
         s2_six_ff   <= six_in;
         s2_hi100_ff <= 33'(s1_hi_ff) * 33'sd100;
         s2_t_ff     <= s1_t_ff;
         s2_lo_ff    <= s1_lo_ff;
      end
      if (out_free) begin
         out_kind_ff  <= out_kind_in;
         out_value_ff <= out_value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         last_co2_ff  <= CO2_LAST_RESET;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= pop;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_free) begin
            out_valid_ff <= s2_valid_ff;
            if (s2_valid_ff && s2_kind_ff == KIND_CO2 && co2_ok) begin
               last_co2_ff <= cand;
            end
         end
      end
   end

endmodule

[hdl/sensor_frame_field_decoder_unit.sv]
// Top level of the sensor frame field decoder: CSR register, front end,
// record queue and back end. Uses sffd_pkg, sffd_front, sffd_queue, sffd_back.
//
//   channel | direction | ports                                   | moves
//   req     | in        | req_valid/ready, req_rx_byte            | one rx byte
//   rsp     | out       | rsp_valid/ready, rsp_record_kind, _value | one record
//   csr     | in        | csr_valid/ready, csr_co2_jump_limit     | limit write
//
// One byte per cycle while the queue is not full; on the transfer of its closing
// '*' a record is written to the queue, then passes through the two arithmetic
// stages and the output register.
// Synchronous reset clears frame state, queue and pipeline valids.
// A stalled rsp fills the pipeline, then the 4-entry queue; req_ready drops
// only when the queue is full.
module sensor_frame_field_decoder_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [3:0]                    rsp_record_kind,
   output logic signed [sffd_pkg::VALUE_W-1:0] rsp_value_hundredths,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sffd_pkg::CO2_W-1:0]    csr_co2_jump_limit
);
   import sffd_pkg::*;

   logic [CO2_W-1:0]  co2_limit_ff;
   sffd_qstat_type    q_stat;
   sffd_rec_type      push_rec, head_rec;
   logic              push, pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         co2_limit_ff <= CO2_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         co2_limit_ff <= csr_co2_jump_limit;
      end
   end

   sffd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_stat      (q_stat),
      .push        (push),
      .push_rec    (push_rec)
   );

   sffd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .stat     (q_stat)
   );

   sffd_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_stat               (q_stat),
      .head_rec             (head_rec),
      .pop                  (pop),
      .co2_jump_limit       (co2_limit_ff),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_record_kind      (rsp_record_kind),
      .rsp_value_hundredths (rsp_value_hundredths)
   );

endmodule
